// ===== src/kms_pkg.sv =====
// Shared types, constants and mapping tables of the knob matrix scanner.
`default_nettype none

package kms_pkg;

   localparam int ROWS      = 16;
   localparam int KNOBS     = 14;
   localparam int LINES     = 16;
   localparam int OUT_KNOBS = 14;

   localparam int ROW_BITS  = 4;
   localparam int COL_BITS  = 4;
   localparam int POS_BITS  = 4;
   // The column field always carries 16 lines; only the first LINES of them are wired.
   localparam int LINE_FIELD = 16;
   localparam int REQ_BYTES = (ROW_BITS + LINE_FIELD + 7) / 8;
   localparam int REQ_WIDTH = REQ_BYTES * 8;
   localparam int RSP_WIDTH = ((OUT_KNOBS * POS_BITS + 7) / 8) * 8;

   localparam logic [7:0]          UNMAPPED = 8'hff;
   localparam logic [POS_BITS-1:0] NO_POS   = 4'hf;

   // Physical row to knob position.
   localparam logic [7:0] ROW_TO_POS [16] = '{
      8'd1, 8'd0, 8'd5, 8'd6, 8'd7, 8'd2, 8'd3, 8'd4,
      8'd9, 8'd8, UNMAPPED, UNMAPPED, UNMAPPED, 8'd10, 8'd11, 8'd2
   };

   // Physical column to knob number.
   localparam logic [7:0] COL_TO_KNOB [16] = '{
      8'd1, 8'd3, 8'd5, 8'd7, 8'd9, UNMAPPED, 8'd13, 8'd11,
      8'd12, 8'd10, UNMAPPED, 8'd8, 8'd6, 8'd4, 8'd2, 8'd0
   };

   typedef struct packed {
      logic                mapped;
      logic [COL_BITS-1:0] column;
   } kms_col_map_type;

   // Control shared by all knob lanes for the transaction being accepted.
   typedef struct packed {
      logic                accept;
      logic                scan_start;
      logic                scan_end;
      logic                row_hit;
      logic [POS_BITS-1:0] pos;
   } kms_ctrl_type;

   typedef struct packed {
      logic [POS_BITS-1:0] pos_next;
      logic                change;
   } kms_lane_out_type;

   // Inverse of the column table: which column (if any) drives a knob.
   function automatic kms_col_map_type knob_column(input int knob);
      kms_col_map_type m;
      m = '0;
      for (int c = 0; c < LINES; c++) begin
         if (COL_TO_KNOB[c] == knob[7:0]) begin
            m.mapped = 1'b1;
            m.column = c[COL_BITS-1:0];
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== src/kms_lane.sv =====
// One knob lane: hit mark and stored position of a single knob.
`default_nettype none

module kms_lane
   import kms_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire kms_ctrl_type     ctrl,
   input  wire logic             contact,
   output kms_lane_out_type      lane_out
);

   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic                hit_ff, hit_in;
   logic                hit;
   logic                mark;
   logic [POS_BITS-1:0] hit_pos;
   logic                change;

   always_comb begin
      hit     = ctrl.row_hit && contact;
      mark    = (hit_ff && !ctrl.scan_start) || hit;
      hit_pos = hit ? ctrl.pos : pos_ff;
      change  = hit && (pos_ff != ctrl.pos);
      pos_in  = hit_pos;
      // A knob that saw no contact during the whole scan has no position.
      if (ctrl.scan_end && !mark) begin
         pos_in = NO_POS;
         if (hit_pos != NO_POS) begin
            change = 1'b1;
         end
      end
      hit_in = mark;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= NO_POS;
         hit_ff <= 1'b0;
      end else if (ctrl.accept) begin
         pos_ff <= pos_in;
         hit_ff <= hit_in;
      end
   end

   assign lane_out.pos_next = pos_in;
   assign lane_out.change   = change;

endmodule

`default_nettype wire

// ===== src/kms_merge.sv =====
// Merge stage: combines lane changes, keeps the change flag, registers the result.
`default_nettype none

module kms_merge
   import kms_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire kms_ctrl_type     ctrl,
   input  wire kms_lane_out_type lane_out [KNOBS],
   output logic                  req_ready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_WIDTH-1:0]  rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   logic                 pending_ff, pending_in;
   logic                 valid_ff, valid_in;
   logic [RSP_WIDTH-1:0] data_ff, data_in;
   logic                 last_ff, changed_ff, changed_in;
   logic [KNOBS-1:0]     changes;
   logic                 any_change;

   for (genvar k = 0; k < KNOBS; k++) begin : g_chg
      assign changes[k] = lane_out[k].change;
   end

   for (genvar k = 0; k < OUT_KNOBS; k++) begin : g_pack
      if (k < KNOBS) begin : g_real
         assign data_in[k*POS_BITS +: POS_BITS] = lane_out[k].pos_next;
      end else begin : g_none
         assign data_in[k*POS_BITS +: POS_BITS] = NO_POS;
      end
   end
   if (RSP_WIDTH > OUT_KNOBS * POS_BITS) begin : g_pad
      assign data_in[RSP_WIDTH-1:OUT_KNOBS*POS_BITS] = '0;
   end

   assign any_change = |changes;
   assign req_ready  = !valid_ff || rsp_tready;

   always_comb begin
      changed_in = ctrl.scan_end && (pending_ff || any_change);
      pending_in = ctrl.scan_end ? 1'b0 : (pending_ff || any_change);
      valid_in   = ctrl.accept || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b1;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctrl.accept) begin
            pending_ff <= pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         data_ff    <= data_in;
         last_ff    <= ctrl.scan_end;
         changed_ff <= changed_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = changed_ff;

`ifndef SYNTHESIS
   a_changed_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("change flag reported on a row that does not end a scan");

   a_flag_cleared: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept && ctrl.scan_end |=> !pending_ff)
      else $error("change flag not cleared after scan end");

   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept && !ctrl.scan_end && any_change |=> pending_ff)
      else $error("lane change lost before scan end");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_tready |-> !ctrl.accept)
      else $error("transaction accepted while result is stalled");
`endif

endmodule

`default_nettype wire

// ===== src/knob_matrix_scanner_unit.sv =====
// Top level of the knob matrix scanner: row decode, knob lanes and merge stage.
//
// Each request transaction carries one scanned row: its physical row index and
// the 16 active-low column lines. Every request produces exactly one response
// holding the 14 packed knob positions (15 = no position) after that row is
// applied. Row 0 starts a scan; row 15 ends it, sets knobs that saw no contact
// to 15, and asserts tlast together with the change flag on tuser. One knob
// lane per knob evaluates its own column in parallel and a merge stage gathers
// the results into the response register, so a request is taken every clock
// cycle and its response appears in the cycle after; only a stalled response
// (rsp_tready low) holds off the next request.
`default_nettype none

module knob_matrix_scanner_unit
   import kms_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [REQ_WIDTH-1:0] req_tdata,   // row_index[3:0], column_lines[19:4], zero pad
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_WIDTH-1:0]      rsp_tdata,   // knob_positions[55:0], knob k at 4k+3..4k
   output logic                      rsp_tlast,   // scan_done
   output logic                      rsp_tuser    // changed
);

   logic [ROW_BITS-1:0]   row_index;
   logic [LINE_FIELD-1:0] column_lines;
   logic [7:0]            row_pos;
   logic                  req_ready;
   kms_ctrl_type          ctrl;
   logic [KNOBS-1:0]      contact;
   kms_lane_out_type      lane_out [KNOBS];

   assign row_index    = req_tdata[ROW_BITS-1:0];
   assign column_lines = req_tdata[ROW_BITS +: LINE_FIELD];
   assign row_pos      = ROW_TO_POS[row_index];
   assign req_tready   = req_ready;

   always_comb begin
      ctrl.accept     = req_tvalid && req_ready;
      ctrl.scan_start = (row_index == '0);
      ctrl.scan_end   = ({1'b0, row_index} == 5'(ROWS - 1));
      ctrl.row_hit    = ({1'b0, row_index} < 5'(ROWS)) && (row_pos != UNMAPPED);
      ctrl.pos        = row_pos[POS_BITS-1:0];
   end

   for (genvar k = 0; k < KNOBS; k++) begin : g_lane
      localparam kms_col_map_type MAP = knob_column(k);

      // Active-low contact on the column wired to this knob.
      assign contact[k] = MAP.mapped && !column_lines[MAP.column];

      kms_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .contact  (contact[k]),
         .lane_out (lane_out[k])
      );
   end

   kms_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .lane_out   (lane_out),
      .req_ready  (req_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the knob matrix scanner: directed scans, then random scans.
module testbench;
   import kms_pkg::*;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int PHASE_ROWS   = 600;
   localparam int POSITION_W   = OUT_KNOBS * POS_BITS;
   localparam int LAST_ROW     = ROWS - 1;

   typedef struct packed {
      logic                  scan_done;
      logic                  changed;
      logic [POSITION_W-1:0] positions;
   } scan_report_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_WIDTH-1:0] req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_WIDTH-1:0] rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tuser;

   // Scanner state as the testbench expects it.
   logic [POS_BITS-1:0] knob_pos [16];
   logic                knob_hit [16];
   logic                change_flag;

   scan_report_type pending_reports [$];
   logic [15:0]     scan_layout [16];
   int              sender_gap_pct = 0;
   int              receiver_stall_pct = 0;
   int              rows_sent = 0;
   int              error_count = 0;
   int              cycle_count = 0;

   knob_matrix_scanner_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   function automatic scan_report_type scan_row(input logic [3:0] row, input logic [15:0] cols);
      scan_report_type     rep;
      logic [POS_BITS-1:0] pos;
      logic [7:0]          knob;
      rep = '0;
      if (row == 4'd0) begin
         for (int k = 0; k < 16; k++) knob_hit[k] = 1'b0;
      end
      if (int'(row) < ROWS && ROW_TO_POS[row] != UNMAPPED) begin
         pos = ROW_TO_POS[row][POS_BITS-1:0];
         for (int c = 0; c < LINES; c++) begin
            knob = COL_TO_KNOB[c];
            // A closed contact reads as 0 on its column line.
            if (!cols[c] && knob != UNMAPPED && int'(knob) < KNOBS) begin
               knob_hit[knob] = 1'b1;
               if (knob_pos[knob] != pos) change_flag = 1'b1;
               knob_pos[knob] = pos;
            end
         end
      end
      rep.scan_done = (int'(row) == LAST_ROW);
      if (rep.scan_done) begin
         for (int k = 0; k < KNOBS; k++) begin
            if (!knob_hit[k]) begin
               if (knob_pos[k] != NO_POS) change_flag = 1'b1;
               knob_pos[k] = NO_POS;
            end
         end
         rep.changed = change_flag;
         change_flag = 1'b0;
      end
      for (int k = 0; k < OUT_KNOBS; k++) begin
         rep.positions[POS_BITS*k +: POS_BITS] = (k < KNOBS) ? knob_pos[k] : NO_POS;
      end
      return rep;
   endfunction

   // Mostly a few closed contacts per row, sometimes an arbitrary pattern.
   function automatic logic [15:0] random_columns();
      logic [15:0] cols;
      cols = '1;
      if ($urandom_range(3) == 0) begin
         cols = 16'($urandom);
      end else begin
         for (int c = 0; c < 16; c++) begin
            if ($urandom_range(7) == 0) cols[c] = 1'b0;
         end
      end
      return cols;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      error_count++;
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
   endtask

   task automatic drive_row(input logic [3:0] row, input logic [15:0] cols);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_WIDTH'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, cols, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_reports.push_back(scan_row(row, cols));
      rows_sent++;
   endtask

   task automatic wait_for_reports();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      scan_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("unexpected transaction", '0, 64'(rsp_tdata));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tlast !== want.scan_done)
               report_mismatch("scan_done", 64'(want.scan_done), 64'(rsp_tlast));
            if (rsp_tuser !== want.changed)
               report_mismatch("changed", 64'(want.changed), 64'(rsp_tuser));
            if (rsp_tdata[POSITION_W-1:0] !== want.positions)
               report_mismatch("knob_positions", 64'(want.positions),
                               64'(rsp_tdata[POSITION_W-1:0]));
         end
      end
   end

   task automatic test_after_reset();
      // The change flag comes out of reset set, so only the first report shows it.
      drive_row(4'd15, 16'hffff);
      drive_row(4'd15, 16'hffff);
   endtask

   task automatic test_all_contacts_closed();
      drive_row(4'd0, 16'h0000);
      drive_row(4'd10, 16'h0000);
      drive_row(4'd11, 16'h0000);
      drive_row(4'd12, 16'h0000);
      // Only the two unmapped columns closed.
      drive_row(4'd13, 16'hfbdf);
      drive_row(4'd15, 16'h0000);
   endtask

   task automatic test_repeat_scan();
      // The second identical scan must report no change.
      repeat (2) begin
         drive_row(4'd0, 16'h0000);
         drive_row(4'd15, 16'hffff);
      end
   endtask

   task automatic test_overwrite_restore();
      // Row 0 moves knob 0 away and row 5 moves it back: the scan still reports a change.
      repeat (2) begin
         drive_row(4'd0, 16'h0000);
         drive_row(4'd5, 16'h7fff);
         drive_row(4'd15, 16'hffff);
      end
   endtask

   task automatic test_out_of_order();
      wait_for_reports();
      drive_row(4'd9, 16'heff7);
      drive_row(4'd14, 16'hbffe);
      drive_row(4'd7, 16'h0f0f);
      drive_row(4'd3, 16'hf0f0);
      drive_row(4'd15, 16'h5a5a);
   endtask

   task automatic test_random_scans(input int row_count);
      int          stop_at;
      int          kind;
      int          burst;
      logic [3:0]  row;
      stop_at = rows_sent + row_count;
      while (rows_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            // Complete scan in order; often the same layout so that no change is reported.
            burst = $urandom_range(99);
            if (burst >= 70) begin
               for (int r = 0; r < 16; r++) scan_layout[r] = random_columns();
            end else if (burst >= 40) begin
               scan_layout[$urandom_range(15)] = random_columns();
            end
            for (int r = 0; r < ROWS; r++) drive_row(r[3:0], scan_layout[r]);
         end else if (kind < 85) begin
            // Broken scan: rows skipped, repeated or out of order.
            burst = $urandom_range(1, 20);
            repeat (burst) begin
               row = 4'($urandom_range(15));
               drive_row(row, ($urandom_range(1) == 0) ? scan_layout[row] : random_columns());
            end
         end else begin
            burst = $urandom_range(1, 6);
            repeat (burst) drive_row(4'($urandom_range(15)), 16'($urandom));
         end
         if ($urandom_range(99) < 3) wait_for_reports();
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      for (int k = 0; k < 16; k++) begin
         knob_pos[k]    = NO_POS;
         knob_hit[k]    = 1'b0;
         scan_layout[k] = 16'hffff;
      end
      change_flag = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      sender_gap_pct     = 21;
      receiver_stall_pct = 48;
      test_after_reset();
      test_all_contacts_closed();
      test_repeat_scan();
      test_overwrite_restore();
      test_out_of_order();

      test_random_scans(PHASE_ROWS);
      wait_for_reports();
      sender_gap_pct     = 48;
      receiver_stall_pct = 21;
      test_random_scans(PHASE_ROWS);
      wait_for_reports();
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      test_random_scans(PHASE_ROWS);

      wait_for_reports();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/kms_pkg.sv
src/kms_lane.sv
src/kms_merge.sv
src/knob_matrix_scanner_unit.sv
dv/testbench.sv
